### design/psd_pkg.sv
package psd_pkg;

  localparam int COORD_W           = 12;
  localparam int CFG_W             = 12;
  localparam int CFG_INDEX_W       = 2;
  localparam int DIFF_W            = COORD_W + 2;
  localparam int DEF_WINDOW_FRAMES = 16;

  localparam logic [CFG_W-1:0] X_TRAVEL_RESET = 12'd120;
  localparam logic [CFG_W-1:0] Z_TRAVEL_RESET = 12'd70;
  localparam logic [CFG_W-1:0] Y_DRIFT_RESET  = 12'd45;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_TRAVEL_MIN  = 2'd0,
    REG_Z_TRAVEL_MIN  = 2'd1,
    REG_Y_DRIFT_LIMIT = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    SWIPE_NONE    = 3'd0,
    SWIPE_PLUS_X  = 3'd1,
    SWIPE_MINUS_X = 3'd2,
    SWIPE_PLUS_Z  = 3'd3,
    SWIPE_MINUS_Z = 3'd4
  } swipe_code_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } frame_t;

  typedef struct packed {
    logic up_x;
    logic dn_x;
    logic up_z;
    logic dn_z;
  } trend_t;

  typedef struct packed {
    frame_t frame;
    trend_t trend;
  } cell_t;

  typedef struct packed {
    logic [CFG_W-1:0] x_travel_min;
    logic [CFG_W-1:0] z_travel_min;
    logic [CFG_W-1:0] y_drift_limit;
  } cfg_t;

  function automatic logic signed [DIFF_W-1:0] sext_coord(logic signed [COORD_W-1:0] v);
    return {{(DIFF_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [DIFF_W-1:0] zext_cfg(logic [CFG_W-1:0] v);
    return {{(DIFF_W-CFG_W){1'b0}}, v};
  endfunction

endpackage

### design/psd_if.sv
interface psd_frame_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hand_valid;
  logic signed [psd_pkg::COORD_W-1:0]   palm_x;
  logic signed [psd_pkg::COORD_W-1:0]   palm_y;
  logic signed [psd_pkg::COORD_W-1:0]   palm_z;

  modport source (output valid, hand_valid, palm_x, palm_y, palm_z, input ready);
  modport sink   (input valid, hand_valid, palm_x, palm_y, palm_z, output ready);
endinterface

interface psd_swipe_if;
  logic        valid;
  logic        ready;
  logic [2:0]  swipe_code;
  logic        window_full;

  modport source (output valid, swipe_code, window_full, input ready);
  modport sink   (input valid, swipe_code, window_full, output ready);
endinterface

### design/psd_cell.sv
module psd_cell (
  input  logic            clk,
  input  logic            shift,
  input  psd_pkg::cell_t  d,
  output psd_pkg::cell_t  q
);

  psd_pkg::cell_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

### design/psd_eval.sv
module psd_eval #(
  parameter int WINDOW_FRAMES = psd_pkg::DEF_WINDOW_FRAMES
) (
  input  psd_pkg::frame_t                        new_frame,
  input  psd_pkg::cell_t [WINDOW_FRAMES-1:0]     cells,
  input  psd_pkg::cfg_t                          cfg,
  output psd_pkg::trend_t                        new_trend,
  output psd_pkg::swipe_code_t                   code
);

  logic                              all_up_x, all_dn_x, all_up_z, all_dn_z;
  logic signed [psd_pkg::DIFF_W-1:0] dx, dy, dz, x_min, z_min, y_lim;
  logic                              flat;
  psd_pkg::frame_t                   oldest;

  always_comb begin
    new_trend.up_x = new_frame.x >= cells[0].frame.x;
    new_trend.dn_x = new_frame.x <= cells[0].frame.x;
    new_trend.up_z = new_frame.z >= cells[0].frame.z;
    new_trend.dn_z = new_frame.z <= cells[0].frame.z;
  end

  always_comb begin
    all_up_x = new_trend.up_x;
    all_dn_x = new_trend.dn_x;
    all_up_z = new_trend.up_z;
    all_dn_z = new_trend.dn_z;
    for (int i = 0; i < WINDOW_FRAMES - 2; i++) begin
      all_up_x = all_up_x & cells[i].trend.up_x;
      all_dn_x = all_dn_x & cells[i].trend.dn_x;
      all_up_z = all_up_z & cells[i].trend.up_z;
      all_dn_z = all_dn_z & cells[i].trend.dn_z;
    end
  end

  assign oldest = cells[WINDOW_FRAMES-2].frame;
  assign dx     = psd_pkg::sext_coord(new_frame.x) - psd_pkg::sext_coord(oldest.x);
  assign dy     = psd_pkg::sext_coord(new_frame.y) - psd_pkg::sext_coord(oldest.y);
  assign dz     = psd_pkg::sext_coord(new_frame.z) - psd_pkg::sext_coord(oldest.z);
  assign x_min  = psd_pkg::zext_cfg(cfg.x_travel_min);
  assign z_min  = psd_pkg::zext_cfg(cfg.z_travel_min);
  assign y_lim  = psd_pkg::zext_cfg(cfg.y_drift_limit);
  assign flat   = (dy < y_lim) && (-dy < y_lim);

  always_comb begin
    code = psd_pkg::SWIPE_NONE;
    if (flat) begin
      if (all_up_x && dx >= x_min) begin
        code = psd_pkg::SWIPE_PLUS_X;
      end else if (all_dn_x && -dx >= x_min) begin
        code = psd_pkg::SWIPE_MINUS_X;
      end else if (all_up_z && dz >= z_min) begin
        code = psd_pkg::SWIPE_PLUS_Z;
      end else if (all_dn_z && -dz >= z_min) begin
        code = psd_pkg::SWIPE_MINUS_Z;
      end
    end
  end

endmodule

### design/palm_swipe_direction_detector.sv
// Palm swipe direction detector.
// frame_in carries one tracked-hand frame per transfer (hand_valid and the
// palm x, y, z in millimetres). swipe_out carries one result per frame:
// swipe_code (none, +x, -x, +z, -z) and window_full.
// A row of WINDOW_FRAMES cells holds the recent valid frames, newest in
// cell 0, each with its trend flags against the next older frame; a valid
// frame shifts the row by one. An invalid frame leaves the row and clears the
// run count, so a swipe needs WINDOW_FRAMES valid frames in a row again.
// The result is in the output register in the cycle after the input
// transfer. Throughput: one frame per cycle while swipe_out takes
// results, set by the combinational compare of the new frame to the row.
// cfg_we/cfg_index/cfg_data write x_travel_min, z_travel_min and
// y_drift_limit; write them only while no frame is in flight.
// Reset clears the run count and out_valid and restores the register
// defaults (120, 70, 45). When swipe_out stalls, the output register holds
// and frame_in.ready drops until the result is taken.
module palm_swipe_direction_detector #(
  parameter int WINDOW_FRAMES = psd_pkg::DEF_WINDOW_FRAMES
) (
  input  logic                              clk,
  input  logic                              rst,
  psd_frame_if.sink                         frame_in,
  psd_swipe_if.source                       swipe_out,
  input  logic                              cfg_we,
  input  logic [psd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [psd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int RUN_W = $clog2(WINDOW_FRAMES + 1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(WINDOW_FRAMES);

  psd_pkg::cfg_t                       cfg;
  logic [RUN_W-1:0]                    valid_run, valid_run_next;
  logic                                out_valid;
  psd_pkg::swipe_code_t                out_code;
  logic                                out_full;
  logic                                take, shift, full_now;
  psd_pkg::frame_t                     new_frame;
  psd_pkg::trend_t                     new_trend;
  psd_pkg::swipe_code_t                eval_code;
  psd_pkg::cell_t [WINDOW_FRAMES-1:0]  cells;
  psd_pkg::cell_t                      new_cell;

  assign frame_in.ready = !out_valid || swipe_out.ready;
  assign take           = frame_in.valid && frame_in.ready;
  assign shift          = take && frame_in.hand_valid;

  assign new_frame.x = frame_in.palm_x;
  assign new_frame.y = frame_in.palm_y;
  assign new_frame.z = frame_in.palm_z;
  assign new_cell.frame = new_frame;
  assign new_cell.trend = new_trend;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_travel_min  <= psd_pkg::X_TRAVEL_RESET;
      cfg.z_travel_min  <= psd_pkg::Z_TRAVEL_RESET;
      cfg.y_drift_limit <= psd_pkg::Y_DRIFT_RESET;
    end else if (cfg_we) begin
      unique case (psd_pkg::cfg_index_t'(cfg_index))
        psd_pkg::REG_X_TRAVEL_MIN:  cfg.x_travel_min  <= cfg_data;
        psd_pkg::REG_Z_TRAVEL_MIN:  cfg.z_travel_min  <= cfg_data;
        psd_pkg::REG_Y_DRIFT_LIMIT: cfg.y_drift_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < WINDOW_FRAMES; i++) begin : g_cell
    psd_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     ((i == 0) ? new_cell : cells[(i == 0) ? 0 : i - 1]),
      .q     (cells[i])
    );
  end

  psd_eval #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_eval (
    .new_frame (new_frame),
    .cells     (cells),
    .cfg       (cfg),
    .new_trend (new_trend),
    .code      (eval_code)
  );

  always_comb begin
    if (!frame_in.hand_valid) begin
      valid_run_next = '0;
    end else if (valid_run < RUN_FULL) begin
      valid_run_next = valid_run + RUN_W'(1);
    end else begin
      valid_run_next = valid_run;
    end
  end

  assign full_now = frame_in.hand_valid && (valid_run_next == RUN_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_run <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        valid_run <= valid_run_next;
        out_valid <= 1'b1;
      end else if (swipe_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_full <= full_now;
      out_code <= full_now ? eval_code : psd_pkg::SWIPE_NONE;
    end
  end

  assign swipe_out.valid       = out_valid;
  assign swipe_out.swipe_code  = out_code;
  assign swipe_out.window_full = out_full;

  a_code_needs_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_code != psd_pkg::SWIPE_NONE |-> out_full)
    else $error("swipe reported without a full window");

  a_invalid_clears: assert property (@(posedge clk) disable iff (rst)
    take && !frame_in.hand_valid |=> valid_run == '0 && out_valid && !out_full)
    else $error("invalid frame did not clear the run");

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_run <= RUN_FULL)
    else $error("run count beyond window size");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && valid_run == '0)
    else $error("reset did not empty the block");

endmodule
